[rtl/core/tkpq_pkg.sv]
package tkpq_pkg;

    localparam int DEF_CAPACITY = 16;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        STAT_INSERTED = 2'd0,
        STAT_REMOVED  = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        t_func       func;
        logic [31:0] entry_id;
        logic [7:0]  entry_priority;
        logic [31:0] entry_time;
    } t_request;

    typedef struct packed {
        t_status     status;
        logic [31:0] out_id;
        logic [7:0]  out_priority;
    } t_result;

    typedef struct packed {
        logic [31:0] id;
        logic [7:0]  pri;
        logic [31:0] stamp;
    } t_slot;

    // True when slot a is served before slot b; a_seq_lt tells whether a arrived first.
    function automatic logic goes_first(t_slot a, t_slot b, logic a_seq_lt);
        logic result;
        if (a.pri != b.pri) begin
            result = (a.pri > b.pri);
        end else if (a.stamp != b.stamp) begin
            result = (a.stamp < b.stamp);
        end else begin
            result = a_seq_lt;
        end
        return result;
    endfunction

endpackage

[rtl/core/tkpq_ram.sv]
module tkpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/two_key_priority_queue_core.sv]
// Bounded priority queue of up to CAPACITY entries held in one single-port-read RAM.
// A request is taken when start is high and busy is low. An insert, a remove on an
// empty queue and an insert on a full queue are answered without busy going high. A
// remove keeps busy high for two passes (one for a single entry): the RAM read port
// delivers one entry per cycle to a single comparator that finds the best entry, then
// a second pass through the read port renumbers the arrival ranks and moves the last
// entry into the freed slot. Every request gives one result on o_res, marked by
// o_strobe for exactly one cycle; the receiver cannot stall it and must take it in
// that cycle. A remove result appears right after its scan pass, while the renumbering
// pass, if there is one, still runs.
module two_key_priority_queue_core #(
    parameter int CAPACITY = tkpq_pkg::DEF_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  tkpq_pkg::t_request i_req,
    output logic               o_strobe,
    output tkpq_pkg::t_result  o_res
);

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int SEQ_W  = IDX_W;
    localparam int SLOT_W = $bits(tkpq_pkg::t_slot);
    localparam int RAM_W  = SLOT_W + SEQ_W;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_SCAN     = 5'b00010,
        S_TAIL     = 5'b00100,
        S_FIX      = 5'b01000,
        S_FIX_TAIL = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [IDX_W-1:0]     r_last, n_last;
    logic                 r_dv, n_dv;
    logic [IDX_W-1:0]     r_didx, n_didx;
    tkpq_pkg::t_slot      r_best_slot, n_best_slot;
    logic [SEQ_W-1:0]     r_best_seq, n_best_seq;
    logic [IDX_W-1:0]     r_best_idx, n_best_idx;
    tkpq_pkg::t_slot      r_last_slot, n_last_slot;
    logic [SEQ_W-1:0]     r_last_seq, n_last_seq;
    logic                 r_strobe, n_strobe;
    tkpq_pkg::t_result    r_res, n_res;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [RAM_W-1:0]     ram_wdata;
    logic [RAM_W-1:0]     ram_rdata;
    tkpq_pkg::t_slot      rd_slot;
    logic [SEQ_W-1:0]     rd_seq;
    logic                 cand_wins;
    tkpq_pkg::t_slot      fx_slot;
    logic [SEQ_W-1:0]     fx_seq;
    tkpq_pkg::t_slot      in_slot;
    logic                 accept;

    tkpq_ram #(
        .WIDTH (RAM_W),
        .DEPTH (CAPACITY),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    assign rd_slot = tkpq_pkg::t_slot'(ram_rdata[RAM_W-1:SEQ_W]);
    assign rd_seq  = ram_rdata[SEQ_W-1:0];

    assign in_slot = {i_req.entry_id, i_req.entry_priority, i_req.entry_time};

    assign cand_wins = (r_didx == '0)
                    || tkpq_pkg::goes_first(rd_slot, r_best_slot, rd_seq < r_best_seq);

    always_comb begin
        fx_slot = (r_didx == r_best_idx) ? r_last_slot : rd_slot;
        fx_seq  = (r_didx == r_best_idx) ? r_last_seq : rd_seq;
        if (fx_seq > r_best_seq) begin
            fx_seq = fx_seq - 1'b1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_last      = r_last;
        n_dv        = 1'b0;
        n_didx      = r_idx;
        n_best_slot = r_best_slot;
        n_best_seq  = r_best_seq;
        n_best_idx  = r_best_idx;
        n_last_slot = r_last_slot;
        n_last_seq  = r_last_seq;
        n_strobe    = 1'b0;
        n_res       = r_res;
        ram_we      = 1'b0;
        ram_waddr   = r_didx;
        ram_wdata   = {fx_slot, fx_seq};

        if ((r_state == S_SCAN || r_state == S_TAIL) && r_dv) begin
            if (cand_wins) begin
                n_best_slot = rd_slot;
                n_best_seq  = rd_seq;
                n_best_idx  = r_didx;
            end
            if (r_didx == r_last) begin
                n_last_slot = rd_slot;
                n_last_seq  = rd_seq;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_strobe           = 1'b1;
                    n_res.out_id       = '0;
                    n_res.out_priority = '0;
                    if (i_req.func == tkpq_pkg::FUNC_INSERT) begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_res.status = tkpq_pkg::STAT_FULL;
                        end else begin
                            n_res.status = tkpq_pkg::STAT_INSERTED;
                            ram_we       = 1'b1;
                            ram_waddr    = IDX_W'(r_count);
                            ram_wdata    = {in_slot, SEQ_W'(r_count)};
                            n_count      = r_count + 1'b1;
                        end
                    end else if (r_count == '0) begin
                        n_res.status = tkpq_pkg::STAT_EMPTY;
                    end else begin
                        n_strobe = 1'b0;
                        n_last   = IDX_W'(r_count - 1'b1);
                        n_idx    = '0;
                        n_state  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_dv   = 1'b1;
                n_didx = r_idx;
                if (r_idx == r_last) begin
                    n_state = S_TAIL;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_TAIL: begin
                n_strobe           = 1'b1;
                n_res.status       = tkpq_pkg::STAT_REMOVED;
                n_res.out_id       = n_best_slot.id;
                n_res.out_priority = n_best_slot.pri;
                n_count            = CNT_W'(r_last);
                n_idx              = '0;
                if (r_last == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                ram_we = r_dv;
                n_dv   = 1'b1;
                n_didx = r_idx;
                if (r_idx == r_last - 1'b1) begin
                    n_state = S_FIX_TAIL;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FIX_TAIL: begin
                ram_we  = r_dv;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_dv     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_dv     <= n_dv;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_last      <= n_last;
        r_didx      <= n_didx;
        r_best_slot <= n_best_slot;
        r_best_seq  <= n_best_seq;
        r_best_idx  <= n_best_idx;
        r_last_slot <= n_last_slot;
        r_last_seq  <= n_last_seq;
        r_res       <= n_res;
    end

endmodule
